// ===== hw/rtl/timed_task_scheduler_core_defines.svh =====
// Assertion macros for the timed task scheduler core.
// Used by the top level; every macro expects clk and rst_n in scope.
`ifndef TIMED_TASK_SCHEDULER_CORE_DEFINES_SVH
`define TIMED_TASK_SCHEDULER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTS_ASSERT_IMP(lbl, ante, cons, msg)
`define TTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tts_pkg.sv =====
// Shared constants, codes and controller/datapath types of the scheduler.
// No dependencies.
package tts_pkg;
    localparam int TASK_SLOTS = 32;
    localparam int TIME_BITS  = 64;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
    localparam int ACT_W      = 3;
    localparam int TASK_W     = 5;
    localparam int EVT_W      = 64;

    localparam logic [ACT_W-1:0] ACT_NOW        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FUTURE     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CANCEL     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RUN        = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CANCEL_ALL = 3'd4;

    localparam logic [1:0] SRC_ID   = 2'd0;
    localparam logic [1:0] SRC_IDX  = 2'd1;
    localparam logic [1:0] SRC_BEST = 2'd2;

    typedef logic [TIME_BITS-1:0] tts_time_t;

    typedef struct packed {
        logic              load;
        logic              dup_step;
        logic              insert;
        logic              find_step;
        logic              set_rej;
        logic              min_step;
        logic              compact_step;
        logic              stat_step;
        logic              take;
        logic [1:0]        take_src;
        logic              emit_status;
        logic [SLOT_W-1:0] idx;
    } tts_cmd_t;

    typedef struct packed {
        logic cur_imm;
        logic found;
        logic best_found;
        logic out_free;
    } tts_sts_t;

    function automatic logic [EVT_W-1:0] widen_time(input tts_time_t t);
        logic [EVT_W-1:0] r;
        r = '0;
        r[TIME_BITS-1:0] = t;
        return r;
    endfunction
endpackage

// ===== hw/rtl/tts_in_if.sv =====
// Input channel of the scheduler: valid, ready and one request item.
// Depends on tts_pkg.
interface tts_in_if import tts_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [TASK_W-1:0] task_id;
    logic [EVT_W-1:0]  event_time;
    modport source (output valid, action, task_id, event_time, input ready);
    modport sink (input valid, action, task_id, event_time, output ready);
endinterface

// ===== hw/rtl/tts_out_if.sv =====
// Output channel of the scheduler: valid, ready and one result item.
// Depends on tts_pkg.
interface tts_out_if import tts_pkg::*;;
    logic              valid;
    logic              ready;
    logic              is_status;
    logic [TASK_W-1:0] run_task;
    logic              run_status;
    logic              tasks_left;
    logic [EVT_W-1:0]  next_due;
    logic              rejected;
    logic              last;
    modport source (output valid, is_status, run_task, run_status, tasks_left, next_due,
                     rejected, last, input ready);
    modport sink (input valid, is_status, run_task, run_status, tasks_left, next_due,
                   rejected, last, output ready);
endinterface

// ===== hw/rtl/tts_datapath.sv =====
// Datapath of the scheduler: slot store, scan accumulators and output register.
// Depends on tts_pkg and tts_out_if; driven by tts_ctrl commands.
module tts_datapath import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tts_cmd_t          cmd,
    output tts_sts_t          sts,
    input  logic [ACT_W-1:0]  in_action,
    input  logic [TASK_W-1:0] in_task_id,
    input  logic [EVT_W-1:0]  in_event_time,
    tts_out_if.source         rsp
);
    logic [TASK_SLOTS-1:0] valid_reg;
    logic [TASK_SLOTS-1:0] valid_next;
    logic [TASK_W-1:0]     slot_task_reg  [TASK_SLOTS];
    logic                  slot_timed_reg [TASK_SLOTS];
    tts_time_t             slot_due_reg   [TASK_SLOTS];

    logic [ACT_W-1:0]  action_reg;
    logic [TASK_W-1:0] id_reg;
    tts_time_t         time_reg;
    logic              dup_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic              rej_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_pos_reg;
    logic [TASK_W-1:0] best_task_reg;
    tts_time_t         best_due_reg;
    logic [CNT_W-1:0]  j_reg;
    logic              has_reg;
    logic              imm_reg;
    tts_time_t         mind_reg;

    logic              out_valid_reg;
    logic              out_is_status_reg;
    logic [TASK_W-1:0] out_task_reg;
    logic              out_run_status_reg;
    logic              out_has_reg;
    logic [EVT_W-1:0]  out_due_reg;
    logic              out_rej_reg;

    logic              cur_valid;
    logic [TASK_W-1:0] cur_task;
    logic              cur_timed;
    tts_time_t         cur_due;
    logic              first_step;
    logic              insert_ok;
    logic [SLOT_W-1:0] ins_idx;
    logic [CNT_W-1:0]  j_eff;
    logic [SLOT_W-1:0] j_idx;
    logic              bf_eff;
    logic              min_qual;
    logic              has_eff;
    logic              imm_eff;
    tts_time_t         mind_eff;
    logic [TASK_W-1:0] take_task;

    assign cur_valid  = valid_reg[cmd.idx];
    assign cur_task   = slot_task_reg[cmd.idx];
    assign cur_timed  = slot_timed_reg[cmd.idx];
    assign cur_due    = slot_due_reg[cmd.idx];
    assign first_step = (cmd.idx == '0);
    assign insert_ok  = cmd.insert && !dup_reg && (cnt_reg < CNT_W'(TASK_SLOTS));
    assign ins_idx    = cnt_reg[SLOT_W-1:0];
    assign j_eff      = first_step ? '0 : j_reg;
    assign j_idx      = j_eff[SLOT_W-1:0];
    assign bf_eff     = first_step ? 1'b0 : best_found_reg;
    assign min_qual   = cur_valid && cur_timed && (cur_due <= time_reg)
                        && (!bf_eff || (cur_due < best_due_reg));
    assign has_eff    = first_step ? 1'b0 : has_reg;
    assign imm_eff    = first_step ? 1'b0 : imm_reg;
    assign mind_eff   = first_step ? '1 : mind_reg;

    assign sts.cur_imm    = cur_valid && !cur_timed;
    assign sts.found      = found_reg;
    assign sts.best_found = best_found_reg;
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (cmd.take_src)
            SRC_ID:   take_task = id_reg;
            SRC_IDX:  take_task = cur_task;
            SRC_BEST: take_task = best_task_reg;
            default:  take_task = id_reg;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (insert_ok)
        begin
            valid_next[ins_idx] = 1'b1;
        end
        if (cmd.take)
        begin
            case (cmd.take_src)
                SRC_ID:   valid_next[pos_reg] = 1'b0;
                SRC_IDX:  valid_next[cmd.idx] = 1'b0;
                SRC_BEST: valid_next[best_pos_reg] = 1'b0;
                default:  valid_next[pos_reg] = 1'b0;
            endcase
        end
        if (cmd.compact_step && cur_valid && (j_idx != cmd.idx))
        begin
            valid_next[cmd.idx] = 1'b0;
            valid_next[j_idx]   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            dup_reg        <= 1'b0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            rej_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            j_reg          <= '0;
            has_reg        <= 1'b0;
            imm_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.take || cmd.emit_status)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                dup_reg   <= 1'b0;
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                rej_reg   <= 1'b0;
            end
            if (cmd.dup_step && cur_valid)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cur_task == id_reg)
                begin
                    dup_reg <= 1'b1;
                end
            end
            if ((cmd.insert && !insert_ok) || cmd.set_rej)
            begin
                rej_reg <= 1'b1;
            end
            if (cmd.find_step && cur_valid && (cur_task == id_reg))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.min_step)
            begin
                best_found_reg <= min_qual ? 1'b1 : bf_eff;
            end
            if (cmd.compact_step)
            begin
                j_reg <= cur_valid ? (j_eff + CNT_W'(1)) : j_eff;
            end
            if (cmd.stat_step)
            begin
                has_reg <= has_eff || cur_valid;
                imm_reg <= imm_eff || (cur_valid && !cur_timed);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            id_reg     <= in_task_id;
            time_reg   <= (in_action == ACT_CANCEL_ALL) ? '1 : in_event_time[TIME_BITS-1:0];
        end
        if (cmd.find_step && cur_valid && (cur_task == id_reg) && !found_reg)
        begin
            pos_reg <= cmd.idx;
        end
        if (cmd.min_step && min_qual)
        begin
            best_pos_reg  <= cmd.idx;
            best_task_reg <= cur_task;
            best_due_reg  <= cur_due;
        end
        if (cmd.stat_step)
        begin
            mind_reg <= (cur_valid && cur_timed && (cur_due < mind_eff)) ? cur_due : mind_eff;
        end
        if (insert_ok)
        begin
            slot_task_reg[ins_idx]  <= id_reg;
            slot_timed_reg[ins_idx] <= (action_reg == ACT_FUTURE);
            slot_due_reg[ins_idx]   <= (action_reg == ACT_FUTURE) ? time_reg : '0;
        end
        if (cmd.compact_step && cur_valid)
        begin
            slot_task_reg[j_idx]  <= cur_task;
            slot_timed_reg[j_idx] <= cur_timed;
            slot_due_reg[j_idx]   <= cur_due;
        end
        if (cmd.take)
        begin
            out_is_status_reg  <= 1'b0;
            out_task_reg       <= take_task;
            out_run_status_reg <= (action_reg != ACT_RUN);
            out_has_reg        <= 1'b0;
            out_due_reg        <= '0;
            out_rej_reg        <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_is_status_reg  <= 1'b1;
            out_task_reg       <= '0;
            out_run_status_reg <= 1'b0;
            out_has_reg        <= has_reg;
            out_due_reg        <= imm_reg ? '0 : widen_time(mind_reg);
            out_rej_reg        <= rej_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.is_status  = out_is_status_reg;
    assign rsp.run_task   = out_task_reg;
    assign rsp.run_status = out_run_status_reg;
    assign rsp.tasks_left = out_has_reg;
    assign rsp.next_due   = out_due_reg;
    assign rsp.rejected   = out_rej_reg;
    assign rsp.last       = out_is_status_reg;
endmodule

// ===== hw/rtl/tts_ctrl.sv =====
// Controller of the scheduler: sequences slot scans and result items.
// Depends on tts_pkg; commands tts_datapath.
module tts_ctrl import tts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [ACT_W-1:0] req_action,
    output logic             req_ready,
    input  tts_sts_t         sts,
    output tts_cmd_t         cmd
);
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DUP      = 4'd1;
    localparam logic [3:0] ST_INSERT   = 4'd2;
    localparam logic [3:0] ST_FIND     = 4'd3;
    localparam logic [3:0] ST_CANCEL   = 4'd4;
    localparam logic [3:0] ST_IMM      = 4'd5;
    localparam logic [3:0] ST_MIN      = 4'd6;
    localparam logic [3:0] ST_MIN_EMIT = 4'd7;
    localparam logic [3:0] ST_COMPACT  = 4'd8;
    localparam logic [3:0] ST_STAT     = 4'd9;
    localparam logic [3:0] ST_STATUS   = 4'd10;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              last_idx;

    assign last_idx = (idx_reg == SLOT_W'(TASK_SLOTS - 1));

    always_comb
    begin
        cmd        = '0;
        cmd.idx    = idx_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    case (req_action)
                        ACT_NOW, ACT_FUTURE:     state_next = ST_DUP;
                        ACT_CANCEL:              state_next = ST_FIND;
                        ACT_RUN, ACT_CANCEL_ALL: state_next = ST_IMM;
                        default:                 state_next = ST_STAT;
                    endcase
                end
            end
            ST_DUP:
            begin
                cmd.dup_step = 1'b1;
                idx_next     = last_idx ? '0 : idx_reg + SLOT_W'(1);
                if (last_idx)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                idx_next   = '0;
                state_next = ST_STAT;
            end
            ST_FIND:
            begin
                cmd.find_step = 1'b1;
                idx_next      = last_idx ? '0 : idx_reg + SLOT_W'(1);
                if (last_idx)
                begin
                    state_next = ST_CANCEL;
                end
            end
            ST_CANCEL:
            begin
                idx_next = '0;
                if (!sts.found)
                begin
                    cmd.set_rej = 1'b1;
                    state_next  = ST_STAT;
                end
                else if (sts.out_free)
                begin
                    cmd.take     = 1'b1;
                    cmd.take_src = SRC_ID;
                    state_next   = ST_COMPACT;
                end
            end
            ST_IMM:
            begin
                if (!sts.cur_imm || sts.out_free)
                begin
                    cmd.take     = sts.cur_imm;
                    cmd.take_src = SRC_IDX;
                    idx_next     = last_idx ? '0 : idx_reg + SLOT_W'(1);
                    if (last_idx)
                    begin
                        state_next = ST_MIN;
                    end
                end
            end
            ST_MIN:
            begin
                cmd.min_step = 1'b1;
                idx_next     = last_idx ? '0 : idx_reg + SLOT_W'(1);
                if (last_idx)
                begin
                    state_next = ST_MIN_EMIT;
                end
            end
            ST_MIN_EMIT:
            begin
                idx_next = '0;
                if (!sts.best_found)
                begin
                    state_next = ST_COMPACT;
                end
                else if (sts.out_free)
                begin
                    cmd.take     = 1'b1;
                    cmd.take_src = SRC_BEST;
                    state_next   = ST_MIN;
                end
            end
            ST_COMPACT:
            begin
                cmd.compact_step = 1'b1;
                idx_next         = last_idx ? '0 : idx_reg + SLOT_W'(1);
                if (last_idx)
                begin
                    state_next = ST_STAT;
                end
            end
            ST_STAT:
            begin
                cmd.stat_step = 1'b1;
                idx_next      = last_idx ? '0 : idx_reg + SLOT_W'(1);
                if (last_idx)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

// ===== hw/rtl/timed_task_scheduler_core.sv =====
// A schedule runs a duplicate scan, an insert and a status scan; a cancel runs a find scan,
// a compaction scan and a status scan (no compaction for an absent id); a run or cancel-all
// runs a release scan for immediate tasks, repeats a full minimum scan until no timed task is due,
// then compaction and status scans. Scans visit one slot per cycle, but the release scan stalls on a busy output.
// One item is processed at a time; results leave through a one-deep output register.
// Reset clears all slot valid bits, the controller and the output register at once.
`include "timed_task_scheduler_core_defines.svh"
module timed_task_scheduler_core import tts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tts_in_if.sink   req,
    tts_out_if.source rsp
);
    tts_cmd_t cmd;
    tts_sts_t sts;
    logic     ready;

    assign req.ready = ready;

    tts_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    tts_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_action     (req.action),
        .in_task_id    (req.task_id),
        .in_event_time (req.event_time),
        .rsp           (rsp)
    );

    `TTS_ASSERT_NXT(a_busy_after_accept, req.valid && ready, !ready, "ready after accept")
    `TTS_ASSERT_IMP(a_notice_fields, rsp.valid && !rsp.is_status, !rsp.last && !rsp.rejected && !rsp.tasks_left, "notice item has status fields set")
    `TTS_ASSERT_IMP(a_one_emit, cmd.take, !cmd.emit_status, "notice and status issued together")
endmodule

// ===== bench/tb_timed_task_scheduler_core.sv =====
// Testbench for timed_task_scheduler_core: drives request items, predicts every
// result from a behavioral copy of the task store and checks them in order.
// Depends on tts_pkg, tts_in_if, tts_out_if and the core itself.
`timescale 1ns / 1ps

typedef struct packed {
    logic        is_status;
    logic [4:0]  run_task;
    logic        run_status;
    logic        tasks_left;
    logic [63:0] next_due;
    logic        rejected;
    logic        last;
} sched_result_t;

class sched_scoreboard;
    bit          slot_used[32];
    bit [4:0]    slot_id[32];
    bit          slot_timed[32];
    bit [63:0]   slot_due[32];
    sched_result_t pending_results[$];
    int          errors;

    function new();
        errors = 0;
        foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function int count_used();
        int n;
        n = 0;
        foreach (slot_used[i]) if (slot_used[i]) n++;
        return n;
    endfunction

    function int locate(bit [4:0] id);
        foreach (slot_used[i]) if (slot_used[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function void compact();
        int j;
        j = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (slot_used[i])
            begin
                slot_id[j] = slot_id[i];
                slot_timed[j] = slot_timed[i];
                slot_due[j] = slot_due[i];
                slot_used[j] = 1;
                j++;
            end
        end
        for (int i = j; i < 32; i++)
        begin
            slot_used[i] = 0;
        end
    endfunction

    function void push_notice(bit [4:0] id, bit cancelled);
        sched_result_t r;
        r = '{1'b0, id, cancelled, 1'b0, 64'd0, 1'b0, 1'b0};
        pending_results.push_back(r);
    endfunction

    function void release_due(bit [63:0] now, bit cancelled);
        int best;
        for (int i = 0; i < 32; i++)
        begin
            if (slot_used[i] && !slot_timed[i])
            begin
                push_notice(slot_id[i], cancelled);
                slot_used[i] = 0;
            end
        end
        forever
        begin
            best = -1;
            for (int i = 0; i < 32; i++)
            begin
                if (slot_used[i] && slot_timed[i] && slot_due[i] <= now &&
                    (best < 0 || slot_due[i] < slot_due[best]))
                    best = i;
            end
            if (best < 0) break;
            push_notice(slot_id[best], cancelled);
            slot_used[best] = 0;
        end
        compact();
    endfunction

    function void note_request(bit [2:0] action, bit [4:0] id, bit [63:0] t);
        bit rej;
        bit has;
        bit imm;
        bit [63:0] nxt;
        int n;
        int p;
        sched_result_t r;
        rej = 0;
        if (action == tts_pkg::ACT_NOW || action == tts_pkg::ACT_FUTURE)
        begin
            n = count_used();
            if (locate(id) >= 0 || n >= 32)
                rej = 1;
            else
            begin
                slot_used[n] = 1;
                slot_id[n] = id;
                slot_timed[n] = (action == tts_pkg::ACT_FUTURE);
                slot_due[n] = (action == tts_pkg::ACT_FUTURE) ? t : 64'd0;
            end
        end
        else if (action == tts_pkg::ACT_CANCEL)
        begin
            p = locate(id);
            if (p < 0)
                rej = 1;
            else
            begin
                push_notice(id, 1'b1);
                slot_used[p] = 0;
                compact();
            end
        end
        else if (action == tts_pkg::ACT_RUN)
            release_due(t, 1'b0);
        else if (action == tts_pkg::ACT_CANCEL_ALL)
            release_due('1, 1'b1);
        has = 0;
        imm = 0;
        nxt = '1;
        foreach (slot_used[i])
        begin
            if (slot_used[i])
            begin
                has = 1;
                if (!slot_timed[i]) imm = 1;
                else if (slot_due[i] < nxt) nxt = slot_due[i];
            end
        end
        if (imm) nxt = 0;
        r = '{1'b1, 5'd0, 1'b0, has, nxt, rej, 1'b1};
        pending_results.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
        sched_result_t exp_r;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, actual %p", $time, got);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (got !== exp_r)
        begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
            errors++;
        end
    endfunction
endclass

module tb_timed_task_scheduler_core;
    import tts_pkg::*;

    logic clk;
    logic rst_n;
    tts_in_if req ();
    tts_out_if rsp ();

    timed_task_scheduler_core dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    sched_scoreboard board;
    bit calm_stretch;
    bit hold_off;
    int idle_cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(logic [2:0] action, logic [4:0] id, logic [63:0] t);
        while (!calm_stretch && $urandom_range(99) < 12)
        begin
            req.valid <= 0;
            @(negedge clk);
        end
        req.valid <= 1;
        req.action <= action;
        req.task_id <= id;
        req.event_time <= t;
        do @(posedge clk); while (!req.ready);
        board.note_request(action, id, t);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand_time();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(40));
            2: return '1 - 64'($urandom_range(3));
            default: return 64'($urandom_range(1000));
        endcase
    endfunction

    initial
    begin
        sched_result_t got;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.is_status, rsp.run_task, rsp.run_status, rsp.tasks_left,
                        rsp.next_due, rsp.rejected, rsp.last};
                board.check_result(got);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp.ready <= hold_off ? 1'b0 : (calm_stretch || $urandom_range(99) >= 12);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 20000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int tt;
        board = new();
        calm_stretch = 0;
        hold_off = 0;
        idle_cycles = 0;
        req.valid = 0;
        req.action = 0;
        req.task_id = 0;
        req.event_time = 0;
        rsp.ready = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_request(ACT_NOW, 5'd0, 64'd0);
        send_request(ACT_NOW, 5'd0, 64'd0);
        send_request(ACT_FUTURE, 5'd31, '1);
        send_request(ACT_FUTURE, 5'd7, 64'd100);
        send_request(ACT_FUTURE, 5'd8, 64'd100);
        send_request(ACT_FUTURE, 5'd9, 64'd50);
        send_request(ACT_CANCEL, 5'd20, 64'd0);
        send_request(ACT_CANCEL, 5'd31, '1);
        send_request(3'd5, 5'd3, 64'd5);
        send_request(3'd7, 5'd31, '1);
        send_request(ACT_RUN, 5'd0, 64'd100);
        send_request(ACT_RUN, 5'd0, 64'd0);
        for (int i = 0; i < 32; i++)
            send_request((i % 2) ? ACT_FUTURE : ACT_NOW, 5'(i), 64'(32 - i));
        send_request(ACT_NOW, 5'd3, 64'd0);
        send_request(ACT_CANCEL_ALL, 5'd0, 64'd0);
        send_request(ACT_RUN, 5'd0, '1);

        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
        join_none
        calm_stretch = 1;
        for (int i = 0; i < 30; i++)
        begin
            if (i == 15) calm_stretch = 0;
            tt = $urandom_range(5);
            if (tt < 2)
                send_request(ACT_FUTURE, 5'($urandom), rand_time());
            else if (tt < 3)
                send_request(ACT_NOW, 5'($urandom), rand_time());
            else if (tt < 4)
                send_request(ACT_CANCEL, 5'($urandom), rand_time());
            else
                send_request(ACT_RUN, 5'($urandom), rand_time());
        end
        for (int i = 0; i < 55; i++)
        begin
            tt = $urandom_range(99);
            if (tt < 40)
                send_request(ACT_FUTURE, 5'($urandom), rand_time());
            else if (tt < 60)
                send_request(ACT_NOW, 5'($urandom), {$urandom, $urandom});
            else if (tt < 75)
                send_request(ACT_CANCEL, 5'($urandom), {$urandom, $urandom});
            else if (tt < 92)
                send_request(ACT_RUN, 5'($urandom), rand_time());
            else if (tt < 96)
                send_request(ACT_CANCEL_ALL, 5'($urandom), {$urandom, $urandom});
            else
                send_request(3'($urandom_range(7, 5)), 5'($urandom), {$urandom, $urandom});
        end
        req.valid <= 0;

        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== timed_task_scheduler_core.f =====
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_in_if.sv
hw/rtl/tts_out_if.sv
hw/rtl/tts_datapath.sv
hw/rtl/tts_ctrl.sv
hw/rtl/timed_task_scheduler_core.sv
bench/tb_timed_task_scheduler_core.sv
